>>> rtl/pv_mppt_sense_track_core_assert.svh
// Assertion macros for the PV tracker core.
// Included by the top level; no other dependencies.
`ifndef PV_MPPT_SENSE_TRACK_CORE_ASSERT_SVH
`define PV_MPPT_SENSE_TRACK_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PVMST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvmst assertion failed");
`define PVMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvmst assertion failed");
`else
`define PVMST_ASSERT_SAME(label, clk, rst, ante, cons)
`define PVMST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/pvmst_pkg.sv
// Shared constants, types and register indexes for the PV tracker.
// No dependencies.
`default_nettype none
package pvmst_pkg;
   localparam int SB     = 10;
   localparam int PW     = 2 * SB;
   localparam int CNT_W  = 16;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;
   localparam int REQ_W  = ((4 * SB + 7) / 8) * 8;
   localparam int RSP_W  = ((4 * SB + 7) / 8) * 8;
   localparam int RSP_UW = 3;

   localparam logic [SB-1:0]    ADC_OFFSET_RST   = SB'(512);
   localparam logic [SB-1:0]    CURRENT_TRIP_RST = SB'(130);
   localparam logic [SB-1:0]    DC_LIMIT_RST     = SB'(920);
   localparam logic [SB-1:0]    REF_LIMIT_RST    = SB'(200);
   localparam logic [CNT_W-1:0] DC_PERIOD_RST    = CNT_W'(50);
   localparam logic [CNT_W-1:0] TRACK_PERIOD_RST = CNT_W'(32700);
   localparam logic [SB-1:0]    REF_VALUE_RST    = SB'(80);

   localparam logic [CSR_IW-1:0] CSR_ADC_OFFSET   = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_CURRENT_TRIP = CSR_IW'(1);
   localparam logic [CSR_IW-1:0] CSR_DC_LIMIT     = CSR_IW'(2);
   localparam logic [CSR_IW-1:0] CSR_REF_LIMIT    = CSR_IW'(3);
   localparam logic [CSR_IW-1:0] CSR_DC_PERIOD    = CSR_IW'(4);
   localparam logic [CSR_IW-1:0] CSR_TRACK_PERIOD = CSR_IW'(5);

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   typedef struct packed {
      logic [SB-1:0]    adc_offset;
      logic [SB-1:0]    current_trip;
      logic [SB-1:0]    dc_link_limit;
      logic [SB-1:0]    reference_limit;
      logic [CNT_W-1:0] dc_check_period;
      logic [CNT_W-1:0] track_period;
   } cfg_type;

   typedef struct packed {
      logic          action;
      logic [SB-1:0] link_a_raw;
      logic [SB-1:0] link_b_raw;
      logic [SB-1:0] pv_volt_raw;
      logic [SB-1:0] pv_curr_raw;
   } item_type;

   typedef struct packed {
      logic [SB-1:0] voltage_reference;
      logic [SB-1:0] pv_volt;
      logic [SB-1:0] pv_curr;
      logic [SB-1:0] link_avg;
      logic          overcurrent_fault;
      logic          overvoltage_fault;
      logic          track_done;
   } result_type;

   typedef struct packed {
      logic advance;
      logic oc_flag;
      logic ov_flag;
   } stat_type;
endpackage
`default_nettype wire

>>> rtl/pvmst_csr.sv
// Configuration register bank of the PV tracker.
// Depends on pvmst_pkg.
`default_nettype none
module pvmst_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [pvmst_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [pvmst_pkg::CSR_DW-1:0]   csr_wdata,
   output pvmst_pkg::cfg_type                  cfg
);
   pvmst_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pvmst_pkg::CSR_ADC_OFFSET:   cfg_in.adc_offset      = csr_wdata[pvmst_pkg::SB-1:0];
            pvmst_pkg::CSR_CURRENT_TRIP: cfg_in.current_trip    = csr_wdata[pvmst_pkg::SB-1:0];
            pvmst_pkg::CSR_DC_LIMIT:     cfg_in.dc_link_limit   = csr_wdata[pvmst_pkg::SB-1:0];
            pvmst_pkg::CSR_REF_LIMIT:    cfg_in.reference_limit = csr_wdata[pvmst_pkg::SB-1:0];
            pvmst_pkg::CSR_DC_PERIOD:    cfg_in.dc_check_period =
               csr_wdata[pvmst_pkg::CNT_W-1:0];
            pvmst_pkg::CSR_TRACK_PERIOD: cfg_in.track_period    =
               csr_wdata[pvmst_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adc_offset      <= pvmst_pkg::ADC_OFFSET_RST;
         cfg_ff.current_trip    <= pvmst_pkg::CURRENT_TRIP_RST;
         cfg_ff.dc_link_limit   <= pvmst_pkg::DC_LIMIT_RST;
         cfg_ff.reference_limit <= pvmst_pkg::REF_LIMIT_RST;
         cfg_ff.dc_check_period <= pvmst_pkg::DC_PERIOD_RST;
         cfg_ff.track_period    <= pvmst_pkg::TRACK_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

>>> rtl/pvmst_in_stage.sv
// Input word register of the PV tracker; holds one word until the core takes it.
// Depends on pvmst_pkg.
`default_nettype none
module pvmst_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  pvmst_pkg::item_type      req_item,
   input  pvmst_pkg::stat_type      stat,
   output      logic                item_valid,
   output pvmst_pkg::item_type      item
);
   logic                valid_ff, valid_in;
   pvmst_pkg::item_type item_ff;

   assign req_tready = !valid_ff || stat.advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

>>> rtl/pvmst_core.sv
// Sensing, protection, period counters and tracking step, with the result register.
// Depends on pvmst_pkg.
`default_nettype none
module pvmst_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  pvmst_pkg::cfg_type       cfg,
   input  wire logic                item_valid,
   input  pvmst_pkg::item_type      item,
   input  wire logic                rsp_tready,
   output      logic                rsp_tvalid,
   output pvmst_pkg::result_type    result,
   output pvmst_pkg::stat_type      stat
);
   localparam int SB    = pvmst_pkg::SB;
   localparam int PW    = pvmst_pkg::PW;
   localparam int CNT_W = pvmst_pkg::CNT_W;

   logic [SB-1:0]    ref_ff, ref_in, volt_ff, volt_in, curr_ff, curr_in;
   logic [SB-1:0]    link_a_ff, link_a_in, link_b_ff, link_b_in, avg_ff, avg_in;
   logic [SB-1:0]    volt_prev_ff, volt_prev_in;
   logic [PW-1:0]    power_ff, power_in, power_prev_ff, power_prev_in;
   logic             primed_ff, primed_in, oc_ff, oc_in, ov_ff, ov_in;
   logic [CNT_W-1:0] dc_cnt_ff, dc_cnt_in, tr_cnt_ff, tr_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pvmst_pkg::result_type result_ff, result_in;

   logic             advance, done;
   logic [SB-1:0]    volt_s, curr_s;
   logic [PW-1:0]    prod_s;
   logic [SB:0]      link_sum;
   logic [CNT_W:0]   dc_next, tr_next;
   logic signed [SB+1:0] r_s, lim_s;

   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      volt_s   = (item.pv_volt_raw > cfg.adc_offset) ? item.pv_volt_raw - cfg.adc_offset
                                                     : '0;
      curr_s   = (cfg.adc_offset > item.pv_curr_raw) ? cfg.adc_offset - item.pv_curr_raw
                                                     : '0;
      prod_s   = PW'(volt_s) * PW'(curr_s);
      link_sum = {1'b0, link_a_ff} + {1'b0, link_b_ff};
      dc_next  = {1'b0, dc_cnt_ff} + (CNT_W+1)'(1);
      tr_next  = {1'b0, tr_cnt_ff} + (CNT_W+1)'(1);
      lim_s    = signed'({2'b00, cfg.reference_limit});

      r_s = signed'({2'b00, ref_ff});
      if (power_ff > power_prev_ff) begin
         if (volt_ff > volt_prev_ff) r_s = r_s + (SB+2)'(1);
         if (volt_ff < volt_prev_ff) r_s = r_s - (SB+2)'(1);
      end else if (power_ff < power_prev_ff) begin
         if (volt_ff > volt_prev_ff) r_s = r_s - (SB+2)'(1);
         if (volt_ff < volt_prev_ff) r_s = r_s + (SB+2)'(1);
      end
      if (r_s < 0) r_s = '0;
      if (r_s > lim_s) r_s = lim_s;

      ref_in        = ref_ff;
      volt_in       = volt_ff;
      curr_in       = curr_ff;
      link_a_in     = link_a_ff;
      link_b_in     = link_b_ff;
      avg_in        = avg_ff;
      volt_prev_in  = volt_prev_ff;
      power_in      = power_ff;
      power_prev_in = power_prev_ff;
      primed_in     = primed_ff;
      oc_in         = oc_ff;
      ov_in         = ov_ff;
      dc_cnt_in     = dc_cnt_ff;
      tr_cnt_in     = tr_cnt_ff;
      done          = 1'b0;

      if (advance) begin
         if (item.action == pvmst_pkg::ACT_SAMPLE) begin
            link_a_in = item.link_a_raw;
            link_b_in = item.link_b_raw;
            volt_in   = volt_s;
            curr_in   = curr_s;
            power_in  = prod_s;
            if (curr_s >= cfg.current_trip) oc_in = 1'b1;
            if (!primed_ff) begin
               power_prev_in = prod_s;
               volt_prev_in  = volt_s;
               primed_in     = 1'b1;
            end
         end else begin
            dc_cnt_in = dc_next[CNT_W-1:0];
            tr_cnt_in = tr_next[CNT_W-1:0];
            if (dc_next >= {1'b0, cfg.dc_check_period}) begin
               avg_in    = link_sum[SB:1];
               if (link_sum[SB:1] >= cfg.dc_link_limit) ov_in = 1'b1;
               dc_cnt_in = '0;
            end
            if (tr_next >= {1'b0, cfg.track_period}) begin
               ref_in        = r_s[SB-1:0];
               power_prev_in = power_ff;
               volt_prev_in  = volt_ff;
               tr_cnt_in     = '0;
               done          = 1'b1;
            end
         end
      end

      result_in.voltage_reference = ref_in;
      result_in.pv_volt           = volt_in;
      result_in.pv_curr           = curr_in;
      result_in.link_avg          = avg_in;
      result_in.overcurrent_fault = oc_in;
      result_in.overvoltage_fault = ov_in;
      result_in.track_done        = done;

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff        <= pvmst_pkg::REF_VALUE_RST;
         volt_ff       <= '0;
         curr_ff       <= '0;
         link_a_ff     <= '0;
         link_b_ff     <= '0;
         avg_ff        <= '0;
         volt_prev_ff  <= '0;
         power_ff      <= '0;
         power_prev_ff <= '0;
         primed_ff     <= 1'b0;
         oc_ff         <= 1'b0;
         ov_ff         <= 1'b0;
         dc_cnt_ff     <= '0;
         tr_cnt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ref_ff        <= ref_in;
         volt_ff       <= volt_in;
         curr_ff       <= curr_in;
         link_a_ff     <= link_a_in;
         link_b_ff     <= link_b_in;
         avg_ff        <= avg_in;
         volt_prev_ff  <= volt_prev_in;
         power_ff      <= power_in;
         power_prev_ff <= power_prev_in;
         primed_ff     <= primed_in;
         oc_ff         <= oc_in;
         ov_ff         <= ov_in;
         dc_cnt_ff     <= dc_cnt_in;
         tr_cnt_ff     <= tr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign result       = result_ff;
   assign stat.advance = advance;
   assign stat.oc_flag = oc_ff;
   assign stat.ov_flag = ov_ff;
endmodule
`default_nettype wire

>>> rtl/pv_mppt_sense_track_core.sv
// Path: an accepted req word is held in the input register, then written to
// the result register, which offers the rsp word; rsp back-pressure stalls it.
// Throughput: one word per cycle while rsp is not back-pressured; the tracker
// state updates as the word leaves the input register, so each word sees all
// earlier ones. Reset (synchronous, active high) restores register defaults,
// reference 80, clears faults, counters and both word registers' valid flags.
`default_nettype none
`include "pv_mppt_sense_track_core_assert.svh"
module pv_mppt_sense_track_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // link_a_raw, link_b_raw, pv_volt_raw, pv_curr_raw
   input  wire logic [pvmst_pkg::REQ_W-1:0]       req_tdata,
   // action
   input  wire logic                              req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // voltage_reference, pv_volt, pv_curr, link_avg
   output      logic [pvmst_pkg::RSP_W-1:0]       rsp_tdata,
   // overcurrent_fault, overvoltage_fault, track_done
   output      logic [pvmst_pkg::RSP_UW-1:0]      rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic [pvmst_pkg::CSR_IW-1:0]      csr_index,
   input  wire logic [pvmst_pkg::CSR_DW-1:0]      csr_wdata
);
   localparam int SB = pvmst_pkg::SB;

   pvmst_pkg::cfg_type    cfg;
   pvmst_pkg::item_type   req_item, item;
   pvmst_pkg::result_type result;
   pvmst_pkg::stat_type   stat;
   logic                  item_valid;

   assign req_item.action      = req_tuser;
   assign req_item.link_a_raw  = req_tdata[SB-1:0];
   assign req_item.link_b_raw  = req_tdata[2*SB-1:SB];
   assign req_item.pv_volt_raw = req_tdata[3*SB-1:2*SB];
   assign req_item.pv_curr_raw = req_tdata[4*SB-1:3*SB];

   pvmst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pvmst_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .stat       (stat),
      .item_valid (item_valid),
      .item       (item)
   );

   pvmst_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .result     (result),
      .stat       (stat)
   );

   assign rsp_tdata = pvmst_pkg::RSP_W'({result.link_avg, result.pv_curr, result.pv_volt,
                                         result.voltage_reference});
   assign rsp_tuser = {result.track_done, result.overvoltage_fault,
                       result.overcurrent_fault};

   `PVMST_ASSERT_NEXT(a_oc_sticky, clock, reset, stat.oc_flag, stat.oc_flag)
   `PVMST_ASSERT_NEXT(a_ov_sticky, clock, reset, stat.ov_flag, stat.ov_flag)
   `PVMST_ASSERT_NEXT(a_adv_rsp, clock, reset, stat.advance, rsp_tvalid)
   `PVMST_ASSERT_SAME(a_adv_src, clock, reset, stat.advance, item_valid)
endmodule
`default_nettype wire
